// ===== hw/rtl/mts_pkg.sv =====
// shared constants, codes and types for the min tracking stack
// no dependencies; compiled first
package mts_pkg;

	localparam int DEF_STACK_DEPTH = 64;
	localparam int DEF_VALUE_WIDTH = 32;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_POP_EMPTY  = 2'd1,
		STAT_PUSH_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} ctrl_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic commit;
	} mts_cmd_t;

endpackage

// ===== hw/rtl/mts_if.sv =====
// request and response channel interfaces for the min tracking stack
// depends on mts_pkg
interface mts_req_if #(
	parameter int VALUE_WIDTH = mts_pkg::DEF_VALUE_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface

interface mts_rsp_if #(
	parameter int VALUE_WIDTH = mts_pkg::DEF_VALUE_WIDTH,
	parameter int DEPTH_WIDTH = $clog2(mts_pkg::DEF_STACK_DEPTH + 1)
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] top_value;
	logic signed [VALUE_WIDTH-1:0] min_value;
	logic [DEPTH_WIDTH-1:0]        depth_used;
	logic                          is_empty;
	logic [1:0]                    status;

	modport source (output valid, output top_value, output min_value, output depth_used,
		output is_empty, output status, input ready);
	modport sink   (input valid, input top_value, input min_value, input depth_used,
		input is_empty, input status, output ready);
endinterface

// ===== hw/rtl/mts_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module mts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hw/rtl/mts_ctrl.sv =====
// controller for the min tracking stack: sequences accept, execute and response
// depends on mts_pkg
module mts_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output mts_pkg::mts_cmd_t cmd
);
	import mts_pkg::*;

	ctrl_state_t state_q, state_nxt;
	logic        rsp_valid_q;

	assign req_ready  = (state_q == ST_IDLE);
	assign cmd.accept = req_valid && req_ready;
	// the result register must be free or draining before a commit
	assign cmd.commit = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid  = rsp_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.accept) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				if (cmd.commit) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end
endmodule

// ===== hw/rtl/mts_dp.sv =====
// datapath for the min tracking stack: pointers, cached tops, stack memories, result register
// depends on mts_pkg and mts_ram
module mts_dp #(
	parameter int STACK_DEPTH = mts_pkg::DEF_STACK_DEPTH,
	parameter int VALUE_WIDTH = mts_pkg::DEF_VALUE_WIDTH
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  mts_pkg::mts_cmd_t                        cmd,
	input  logic                                     req_op,
	input  logic signed [VALUE_WIDTH-1:0]            req_value,
	output logic signed [VALUE_WIDTH-1:0]            top_value,
	output logic signed [VALUE_WIDTH-1:0]            min_value,
	output logic [$clog2(STACK_DEPTH+1)-1:0]         depth_used,
	output logic                                     is_empty,
	output logic [1:0]                               status
);
	import mts_pkg::*;

	localparam int PTR_W = $clog2(STACK_DEPTH + 1);
	localparam int AW    = $clog2(STACK_DEPTH);
	localparam int AUX_W = VALUE_WIDTH + PTR_W;

	logic [PTR_W-1:0]              vp_q, mp_q, nxt_vp, nxt_mp;
	logic                          op_q;
	logic signed [VALUE_WIDTH-1:0] value_q, top_q, min_num_q, nxt_top, nxt_mn;
	logic [PTR_W-1:0]              min_cnt_q, nxt_mc;
	status_t                       nxt_status;

	logic                          vram_we, aram_we;
	logic [PTR_W-1:0]              vram_rptr, aram_rptr, aram_wptr;
	logic [VALUE_WIDTH-1:0]        vram_rdata;
	logic [AUX_W-1:0]              aram_rdata;
	logic signed [VALUE_WIDTH-1:0] below_top, below_min;
	logic [PTR_W-1:0]              below_cnt;

	// entries below the cached tops are fetched on accept
	assign vram_rptr = vp_q - PTR_W'(2);
	assign aram_rptr = mp_q - PTR_W'(2);
	assign aram_wptr = mp_q - PTR_W'(1);

	assign below_top = vram_rdata;
	assign below_min = aram_rdata[AUX_W-1:PTR_W];
	assign below_cnt = aram_rdata[PTR_W-1:0];

	mts_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(STACK_DEPTH)) u_value_ram (
		.clk   (clk),
		.we    (vram_we),
		.waddr (vp_q[AW-1:0]),
		.wdata (value_q),
		.re    (cmd.accept),
		.raddr (vram_rptr[AW-1:0]),
		.rdata (vram_rdata)
	);

	// auxiliary stack holds (minimum, count) pairs below the cached one
	mts_ram #(.WIDTH(AUX_W), .DEPTH(STACK_DEPTH)) u_min_ram (
		.clk   (clk),
		.we    (aram_we),
		.waddr (aram_wptr[AW-1:0]),
		.wdata ({min_num_q, min_cnt_q}),
		.re    (cmd.accept),
		.raddr (aram_rptr[AW-1:0]),
		.rdata (aram_rdata)
	);

	always_comb begin
		nxt_vp     = vp_q;
		nxt_mp     = mp_q;
		nxt_top    = top_q;
		nxt_mn     = min_num_q;
		nxt_mc     = min_cnt_q;
		nxt_status = STAT_OK;
		vram_we    = 1'b0;
		aram_we    = 1'b0;
		if (op_q == OP_PUSH) begin
			if (vp_q == PTR_W'(STACK_DEPTH)) begin
				nxt_status = STAT_PUSH_FULL;
			end else begin
				vram_we = cmd.commit;
				nxt_top = value_q;
				nxt_vp  = vp_q + PTR_W'(1);
				if (mp_q == '0) begin
					nxt_mn = value_q;
					nxt_mc = PTR_W'(1);
					nxt_mp = PTR_W'(1);
				end else if (value_q < min_num_q) begin
					// push the cached pair down, new minimum becomes the cache
					aram_we = cmd.commit;
					nxt_mn  = value_q;
					nxt_mc  = PTR_W'(1);
					nxt_mp  = mp_q + PTR_W'(1);
				end else if (value_q == min_num_q) begin
					nxt_mc = min_cnt_q + PTR_W'(1);
				end
			end
		end else begin
			if (vp_q == '0) begin
				nxt_status = STAT_POP_EMPTY;
			end else begin
				nxt_top = below_top;
				nxt_vp  = vp_q - PTR_W'(1);
				if (min_num_q == top_q) begin
					if (min_cnt_q <= PTR_W'(1)) begin
						nxt_mp = mp_q - PTR_W'(1);
						nxt_mn = below_min;
						nxt_mc = below_cnt;
					end else begin
						nxt_mc = min_cnt_q - PTR_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_q <= '0;
			mp_q <= '0;
		end else if (cmd.commit) begin
			vp_q <= nxt_vp;
			mp_q <= nxt_mp;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= req_op;
			value_q <= req_value;
		end
		if (cmd.commit) begin
			top_q      <= nxt_top;
			min_num_q  <= nxt_mn;
			min_cnt_q  <= nxt_mc;
			top_value  <= (nxt_vp == '0) ? {VALUE_WIDTH{1'b1}} : nxt_top;
			min_value  <= (nxt_vp == '0) ? {VALUE_WIDTH{1'b1}} : nxt_mn;
			depth_used <= nxt_vp;
			is_empty   <= (nxt_vp == '0);
			status     <= nxt_status;
		end
	end
endmodule

// ===== hw/rtl/min_tracking_stack.sv =====
// min tracking stack: push/pop of signed values, reports top, minimum and depth
// a request is accepted in ST_IDLE, its stack ram reads are registered, and it commits from ST_EXEC
// into the output register, held back while the previous result still waits there
// requests are taken one at a time: a new request is accepted only after the current one commits
// a new request is taken while the previous result still waits in the output register
// reset clears the stack pointers and handshake state; ram contents are not cleared
// depends on mts_pkg, mts_if, mts_ram, mts_ctrl, mts_dp
module min_tracking_stack #(
	parameter int STACK_DEPTH = mts_pkg::DEF_STACK_DEPTH,
	parameter int VALUE_WIDTH = mts_pkg::DEF_VALUE_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	mts_req_if.sink   req,
	mts_rsp_if.source rsp
);
	import mts_pkg::*;

	mts_cmd_t cmd;

	mts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	mts_dp #(.STACK_DEPTH(STACK_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.req_op     (req.op),
		.req_value  (req.value),
		.top_value  (rsp.top_value),
		.min_value  (rsp.min_value),
		.depth_used (rsp.depth_used),
		.is_empty   (rsp.is_empty),
		.status     (rsp.status)
	);
endmodule

// ===== tb/tb_min_tracking_stack.sv =====
// self-checking testbench for min_tracking_stack: directed and random push/pop traffic
// with its own stack and minimum-track predictor in a small scoreboard class
// depends on mts_pkg, mts_if and the min_tracking_stack rtl
module tb_min_tracking_stack;
	timeunit 1ns;
	timeprecision 1ps;

	import mts_pkg::*;

	localparam int VW          = DEF_VALUE_WIDTH;
	localparam int DEPTH       = DEF_STACK_DEPTH;
	localparam int DW          = $clog2(DEPTH + 1);
	localparam int TOTAL_ITEMS = 1850;
	localparam int IDLE_LIMIT  = 1000;
	localparam int MAX_SHOWN   = 10;

	typedef logic signed [VW-1:0] value_t;

	typedef struct packed {
		value_t         top_value;
		value_t         min_value;
		logic [DW-1:0]  depth_used;
		logic           is_empty;
		status_t        status;
	} stack_result_t;

	typedef struct {
		value_t      num;
		int unsigned count;
	} min_entry_t;

	class stack_scoreboard;
		value_t        values[$];
		min_entry_t    min_track[$];
		stack_result_t expected[$];
		int unsigned   mismatches;
		int unsigned   results_checked;
		int unsigned   pushes;
		int unsigned   pops;
		int unsigned   push_full_cnt;
		int unsigned   pop_empty_cnt;
		int unsigned   min_track_peak;

		function int unsigned depth();
			return values.size();
		endfunction

		function int unsigned pending();
			return expected.size();
		endfunction

		function value_t cur_min();
			return (min_track.size() != 0) ? min_track[min_track.size() - 1].num : value_t'(0);
		endfunction

		// applies one accepted request and queues the state it leaves behind
		function void note_request(logic op, value_t v);
			stack_result_t want;
			min_entry_t    entry;
			int            last;
			want.status = STAT_OK;
			last = int'(min_track.size()) - 1;
			if (op == OP_PUSH) begin
				pushes++;
				if (values.size() >= DEPTH) begin
					want.status = STAT_PUSH_FULL;
					push_full_cnt++;
				end else begin
					if (last < 0) begin
						entry.num = v;
						entry.count = 1;
						min_track.push_back(entry);
					end else if (v < min_track[last].num) begin
						if (min_track.size() < DEPTH) begin
							entry.num = v;
							entry.count = 1;
							min_track.push_back(entry);
						end
					end else if (v == min_track[last].num) begin
						entry = min_track[last];
						entry.count++;
						min_track[last] = entry;
					end
					values.push_back(v);
				end
			end else begin
				pops++;
				if (values.size() == 0) begin
					want.status = STAT_POP_EMPTY;
					pop_empty_cnt++;
				end else begin
					if (last >= 0 && min_track[last].num == values[values.size() - 1]) begin
						entry = min_track[last];
						if (entry.count <= 1) begin
							void'(min_track.pop_back());
						end else begin
							entry.count--;
							min_track[last] = entry;
						end
					end
					void'(values.pop_back());
				end
			end
			if (min_track.size() > min_track_peak)
				min_track_peak = min_track.size();
			want.is_empty = (values.size() == 0);
			want.depth_used = DW'(values.size());
			want.top_value = '1;
			want.min_value = '1;
			if (!want.is_empty) begin
				want.top_value = values[values.size() - 1];
				if (min_track.size() != 0)
					want.min_value = min_track[min_track.size() - 1].num;
			end
			expected.push_back(want);
		endfunction

		function void report(string field, logic [63:0] exp_val, logic [63:0] got_val);
			mismatches++;
			if (mismatches <= MAX_SHOWN)
				$display("result %0d: %s expected %0h got %0h", results_checked, field,
					exp_val, got_val);
		endfunction

		function void check_result(stack_result_t got);
			stack_result_t want;
			results_checked++;
			if (expected.size() == 0) begin
				report("unexpected result, top_value", '0, got.top_value);
				return;
			end
			want = expected.pop_front();
			if (got.top_value !== want.top_value)
				report("top_value", want.top_value, got.top_value);
			if (got.min_value !== want.min_value)
				report("min_value", want.min_value, got.min_value);
			if (got.depth_used !== want.depth_used)
				report("depth_used", want.depth_used, got.depth_used);
			if (got.is_empty !== want.is_empty)
				report("is_empty", want.is_empty, got.is_empty);
			if (got.status !== want.status)
				report("status", want.status, got.status);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	always #5 clk = ~clk;

	mts_req_if #(.VALUE_WIDTH(VW)) req ();
	mts_rsp_if #(.VALUE_WIDTH(VW), .DEPTH_WIDTH(DW)) rsp ();

	min_tracking_stack #(
		.STACK_DEPTH(DEPTH),
		.VALUE_WIDTH(VW)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	stack_scoreboard sb = new;

	bit          req_gaps;
	bit          rsp_gaps;
	int unsigned items_sent;
	int unsigned idle_cycles;

	// result side: random stall before each transaction while rsp_gaps is set
	initial begin
		int unsigned stall;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rsp_gaps ? $urandom_range(0, 8) : 0;
			if (stall != 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (rsp.valid !== 1'b1);
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
			sb.check_result({rsp.top_value, rsp.min_value, rsp.depth_used, rsp.is_empty,
				status_t'(rsp.status)});
	end

	always @(posedge clk) begin
		if ((req.valid === 1'b1 && req.ready === 1'b1) ||
				(rsp.valid === 1'b1 && rsp.ready === 1'b1))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("no transaction for %0d cycles, %0d results outstanding", idle_cycles,
				sb.pending());
			$display("min_tracking_stack test failed");
			$finish;
		end
	end

	// valid stays high across back-to-back items, dropped only for a gap or while draining results
	task automatic send_op(input logic op, input value_t v);
		int unsigned gap;
		gap = req_gaps ? $urandom_range(0, 8) : 0;
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.op <= op;
		req.value <= v;
		do @(posedge clk); while (req.ready !== 1'b1);
		sb.note_request(op, v);
		items_sent++;
	endtask

	task automatic push_val(input value_t v);
		send_op(OP_PUSH, v);
	endtask

	// value is don't-care on pop, so it gets random bits
	task automatic pop_top();
		send_op(OP_POP, value_t'($urandom));
	endtask

	task automatic drain_results();
		req.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic value_t pick_value();
		int unsigned kind;
		kind = $urandom_range(0, 9);
		if (kind <= 4)
			return value_t'($signed($urandom_range(0, 8)) - 4);
		if (kind <= 6)
			return value_t'($urandom);
		if (kind == 7) begin
			case ($urandom_range(0, 3))
				0: return {1'b0, {(VW-1){1'b1}}};
				1: return {1'b1, {(VW-1){1'b0}}};
				2: return '0;
				default: return '1;
			endcase
		end
		// at or just below the current minimum, builds deep runs of minimum entries
		if (sb.depth() == 0)
			return value_t'($urandom);
		return sb.cur_min() - value_t'($urandom_range(0, 2));
	endfunction

	task automatic run_fill();
		repeat (0) @(posedge clk);
		while (sb.depth() < DEPTH) begin
			if ($urandom_range(0, 99) < 85)
				push_val(pick_value());
			else
				pop_top();
		end
		repeat ($urandom_range(1, 3)) push_val(pick_value());
	endtask

	task automatic run_drain();
		while (sb.depth() != 0) begin
			if ($urandom_range(0, 99) < 85)
				pop_top();
			else
				push_val(pick_value());
		end
		repeat ($urandom_range(1, 3)) pop_top();
	endtask

	task automatic run_mixed();
		repeat ($urandom_range(20, 60)) begin
			if ($urandom_range(0, 1) == 0)
				push_val(pick_value());
			else
				pop_top();
		end
	endtask

	initial begin
		bit first_random;
		req.valid <= 1'b0;
		req.op <= OP_PUSH;
		req.value <= '0;
		arst_n <= 1'b0;
		req_gaps = 1'b0;
		rsp_gaps = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty and extreme values, repeated minimums, unwinding to empty
		pop_top();
		push_val({1'b0, {(VW-1){1'b1}}});
		push_val({1'b0, {(VW-1){1'b1}}});
		push_val({1'b1, {(VW-1){1'b0}}});
		push_val({1'b1, {(VW-1){1'b0}}});
		push_val('0);
		push_val('1);
		repeat (6) pop_top();
		pop_top();
		req_gaps = 1'b1;
		rsp_gaps = 1'b1;
		// -1 pushed on empty must still report is_empty low
		push_val('1);
		push_val(-2);
		push_val(-2);
		push_val(1);
		repeat (4) pop_top();
		drain_results();

		first_random = 1'b1;
		while (items_sent < TOTAL_ITEMS) begin
			req_gaps = ($urandom_range(0, 2) != 0);
			rsp_gaps = ($urandom_range(0, 2) != 0);
			case ($urandom_range(0, 2))
				0: run_fill();
				1: run_drain();
				default: run_mixed();
			endcase
			if (first_random || $urandom_range(0, 2) == 0)
				drain_results();
			first_random = 1'b0;
		end

		drain_results();
		repeat (10) @(posedge clk);
		$display("covered %0d pushes (%0d on a full stack) and %0d pops (%0d on empty)",
			sb.pushes, sb.push_full_cnt, sb.pops, sb.pop_empty_cnt);
		$display("%0d results checked, minimum track reached %0d entries, %0d mismatches",
			sb.results_checked, sb.min_track_peak, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("min_tracking_stack test passed");
		end else begin
			$display("min_tracking_stack test failed");
		end
		$finish;
	end

endmodule
